/* design/aqpm_pkg.sv */
package aqpm_pkg;

  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ACC_W   = 60;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned DER_W   = 34;
  localparam int unsigned RES_W   = 31;
  localparam int unsigned MIX_W   = 34;
  localparam int unsigned OUT_SHIFT = 29;

  localparam logic [11:0] SAFETY_FLOOR = 12'd1100;
  localparam logic [11:0] IDLE_PULSE   = 12'd1000;
  localparam logic [11:0] PULSE_MAX    = 12'd4095;

  localparam logic [15:0] GAIN_P_RST      = 16'd6144;
  localparam logic [15:0] GAIN_I_RST      = 16'd819;
  localparam logic [15:0] GAIN_D_RST      = 16'd410;
  localparam logic [15:0] TICK_PERIOD_RST = 16'd655;
  localparam logic [15:0] TICK_RATE_RST   = 16'd100;
  localparam logic [14:0] DEAD_BAND_RST   = 15'd26;

  typedef enum logic [2:0] {
    REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_TICK_PERIOD,
    REG_TICK_RATE, REG_DEAD_BAND, REG_ROLL_RATE_TGT, REG_PITCH_RATE_TGT
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic clear;
  } mac_ctrl_t;

  function automatic logic [11:0] sat_pulse(logic signed [MIX_W-1:0] v);
    logic [11:0] r;
    if (v < 0) begin
      r = 12'd0;
    end else if (v > $signed({{(MIX_W-12){1'b0}}, PULSE_MAX})) begin
      r = PULSE_MAX;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

/* design/aqpm_mac.sv */
module aqpm_mac
  import aqpm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic signed [ACC_W-1:0] mcand_i,
  input  logic [GAIN_W-1:0]       mplier_i,
  output logic                    busy_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [ACC_W-1:0] acc_q, mcand_q;
  logic [GAIN_W-1:0]       mplier_q;
  logic [4:0]              cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q <= 5'(GAIN_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // one multiplier bit per cycle, shift-add
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end
    end else if (cnt_q != '0) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign acc_o  = acc_q;

endmodule

/* design/aqpm_div.sv */
module aqpm_div #(
  parameter int unsigned DIVISOR = 8,
  parameter int unsigned WIDTH   = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [WIDTH-1:0] dividend_i,
  output logic                    busy_o,
  output logic signed [WIDTH-1:0] quot_o
);

  localparam int unsigned RW = $clog2(DIVISOR) + 1;
  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] dvd_q;
  logic [RW-1:0]    rem_q, trial;
  logic             neg_q, qbit;
  logic [CW-1:0]    cnt_q;

  assign trial = {rem_q[RW-2:0], dvd_q[WIDTH-1]};
  assign qbit  = (trial >= RW'(DIVISOR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(WIDTH);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[WIDTH-1];
      dvd_q <= dividend_i[WIDTH-1] ? WIDTH'(-dividend_i) : WIDTH'(dividend_i);
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= qbit ? (trial - RW'(DIVISOR)) : trial;
      dvd_q <= {dvd_q[WIDTH-2:0], qbit};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

/* design/quad_attitude_pid_mixer_top.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tdata: setpoints, angles, gyro rates, thrust, guard; tuser: emergency
// m_axis    | out       | tdata: four motor pulses
// cfg       | in        | cfg_index_i selects register, cfg_data_i value
//
// An item runs four loops and then the mix steps between accept and result, and the
// block returns to idle before the next accept. Each loop runs five products on the
// shared bit-serial multiplier (load, 16 shift-add steps, done) plus error, integrator
// and close steps; rate loops first run the serial window divider.
// A new item is taken once the previous result sits in the output register; the block
// waits only if that result is still not taken.
// Reset clears windows, integrators and previous errors and loads register defaults.
module quad_attitude_pid_mixer_top
  import aqpm_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // roll_setpoint, pitch_setpoint, roll_angle, pitch_angle, roll_rate, pitch_rate,
  // thrust_command, guard_thrust
  input  logic [119:0] s_axis_tdata_i,
  // emergency
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // motor_right_front, motor_left_front, motor_right_back, motor_left_back
  output logic [47:0]  m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned SUM_W = 16 + $clog2(WINDOW_LEN);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_ERR, S_MUL_GO, S_MUL_WAIT,
    S_INT, S_LOOP_END, S_MIX_A, S_MIX_B
  } state_e;

  typedef enum logic [2:0] {PH_INT, PH_DER, PH_P, PH_I, PH_D} phase_e;

  state_e state_q;
  phase_e ph_q;
  logic [1:0] li_q;

  logic [15:0] gain_p_q, gain_i_q, gain_d_q, tick_period_q, tick_rate_q;
  logic [14:0] dead_band_q;
  logic signed [15:0] roll_tgt_q, pitch_tgt_q;

  logic signed [15:0] roll_win_q [WINDOW_LEN];
  logic signed [15:0] pitch_win_q [WINDOW_LEN];
  logic signed [SUM_W-1:0] roll_sum_q, pitch_sum_q;

  logic signed [15:0] roll_sp_q, pitch_sp_q, roll_ang_q, pitch_ang_q;
  logic [11:0] thrust_q;
  logic        idle_q;

  logic signed [ERR_W-1:0]   e_q;
  logic signed [ERR_W-1:0]   prev_q [4];
  logic signed [INTEG_W-1:0] integ_q [4];
  logic signed [DER_W-1:0]   deriv_q;
  logic signed [RES_W-1:0]   res_q [4];
  logic signed [31:0]        mix_a_q, mix_b_q;

  logic        out_valid_q;
  logic [47:0] out_data_q;

  logic accept;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // serial units
  mac_ctrl_t mac_ctrl;
  logic signed [ACC_W-1:0] mac_mcand, mac_acc;
  logic [GAIN_W-1:0]       mac_mplier;
  logic                    mac_busy;

  logic                    div_start, div_busy;
  logic signed [SUM_W-1:0] div_dvd, div_quot;

  logic signed [ERR_W:0] dd;
  assign dd = (ERR_W+1)'(e_q) - (ERR_W+1)'(prev_q[li_q]);

  always_comb begin
    mac_ctrl.load  = (state_q == S_MUL_GO);
    mac_ctrl.clear = (ph_q == PH_INT) || (ph_q == PH_DER) || (ph_q == PH_P);
    case (ph_q)
      PH_INT: begin
        mac_mcand  = ACC_W'(e_q);
        mac_mplier = tick_period_q;
      end
      PH_DER: begin
        mac_mcand  = ACC_W'(dd);
        mac_mplier = tick_rate_q;
      end
      PH_P: begin
        mac_mcand  = ACC_W'(e_q) <<< 8;
        mac_mplier = gain_p_q;
      end
      PH_I: begin
        mac_mcand  = ACC_W'(integ_q[li_q]);
        mac_mplier = gain_i_q;
      end
      PH_D: begin
        mac_mcand  = ACC_W'(deriv_q) <<< 8;
        mac_mplier = gain_d_q;
      end
      default: begin
        mac_mcand  = '0;
        mac_mplier = '0;
      end
    endcase
  end

  aqpm_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .mcand_i  (mac_mcand),
    .mplier_i (mac_mplier),
    .busy_o   (mac_busy),
    .acc_o    (mac_acc)
  );

  assign div_start = (state_q == S_DIV_GO);
  assign div_dvd   = (li_q == 2'd2) ? roll_sum_q : pitch_sum_q;

  aqpm_div #(
    .DIVISOR (WINDOW_LEN),
    .WIDTH   (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // loop error
  logic signed [15:0]      mean;
  logic signed [ERR_W-1:0] e_d;
  assign mean = div_quot[15:0];
  always_comb begin
    case (li_q)
      2'd0:    e_d = ERR_W'(roll_sp_q) - ERR_W'(roll_ang_q);
      2'd1:    e_d = ERR_W'(pitch_sp_q) - ERR_W'(pitch_ang_q);
      2'd2:    e_d = ERR_W'(roll_tgt_q) - ERR_W'(mean);
      default: e_d = ERR_W'(pitch_tgt_q) - ERR_W'(mean);
    endcase
  end

  // integrator update
  logic [ERR_W-1:0]          e_mag;
  logic signed [24:0]        inc;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_d;
  assign e_mag     = e_q[ERR_W-1] ? ERR_W'(-e_q) : ERR_W'(e_q);
  assign inc       = mac_acc[32:8];
  assign integ_sum = (INTEG_W+1)'(integ_q[li_q]) + (INTEG_W+1)'(inc);
  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_d = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_d = integ_sum[INTEG_W-1:0];
    end
  end

  // truncate toward zero
  logic signed [ACC_W-1:0] acc_bias;
  logic signed [RES_W-1:0] res_d;
  assign acc_bias = mac_acc + (mac_acc[ACC_W-1] ? ACC_W'((64'd1 << OUT_SHIFT) - 64'd1) : '0);
  assign res_d    = RES_W'(acc_bias >>> OUT_SHIFT);

  // mixer
  logic signed [MIX_W-1:0] base, ma, mb;
  assign base = MIX_W'({1'b0, thrust_q});
  assign ma   = MIX_W'(mix_a_q);
  assign mb   = MIX_W'(mix_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q      <= GAIN_P_RST;
      gain_i_q      <= GAIN_I_RST;
      gain_d_q      <= GAIN_D_RST;
      tick_period_q <= TICK_PERIOD_RST;
      tick_rate_q   <= TICK_RATE_RST;
      dead_band_q   <= DEAD_BAND_RST;
      roll_tgt_q    <= '0;
      pitch_tgt_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_GAIN_P:         gain_p_q      <= cfg_data_i;
        REG_GAIN_I:         gain_i_q      <= cfg_data_i;
        REG_GAIN_D:         gain_d_q      <= cfg_data_i;
        REG_TICK_PERIOD:    tick_period_q <= cfg_data_i;
        REG_TICK_RATE:      tick_rate_q   <= cfg_data_i;
        REG_DEAD_BAND:      dead_band_q   <= cfg_data_i[14:0];
        REG_ROLL_RATE_TGT:  roll_tgt_q    <= cfg_data_i;
        REG_PITCH_RATE_TGT: pitch_tgt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        roll_win_q[k]  <= '0;
        pitch_win_q[k] <= '0;
      end
      roll_sum_q  <= '0;
      pitch_sum_q <= '0;
    end else if (accept) begin
      roll_win_q[0]  <= s_axis_tdata_i[79:64];
      pitch_win_q[0] <= s_axis_tdata_i[95:80];
      for (int k = 1; k < WINDOW_LEN; k++) begin
        roll_win_q[k]  <= roll_win_q[k-1];
        pitch_win_q[k] <= pitch_win_q[k-1];
      end
      roll_sum_q  <= roll_sum_q + SUM_W'($signed(s_axis_tdata_i[79:64]))
                     - SUM_W'(roll_win_q[WINDOW_LEN-1]);
      pitch_sum_q <= pitch_sum_q + SUM_W'($signed(s_axis_tdata_i[95:80]))
                     - SUM_W'(pitch_win_q[WINDOW_LEN-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      roll_sp_q   <= s_axis_tdata_i[15:0];
      pitch_sp_q  <= s_axis_tdata_i[31:16];
      roll_ang_q  <= s_axis_tdata_i[47:32];
      pitch_ang_q <= s_axis_tdata_i[63:48];
      thrust_q    <= s_axis_tdata_i[107:96];
      idle_q      <= s_axis_tuser_i || (s_axis_tdata_i[119:108] < SAFETY_FLOOR);
    end
    if (state_q == S_ERR) begin
      e_q <= e_d;
    end
    if ((state_q == S_MUL_WAIT) && !mac_busy && (ph_q == PH_DER)) begin
      deriv_q <= mac_acc[DER_W-1:0];
    end
    if (state_q == S_LOOP_END) begin
      res_q[li_q] <= res_d;
    end
    if (state_q == S_MIX_A) begin
      mix_a_q <= 32'(res_q[0]) - 32'(res_q[2]);
      mix_b_q <= 32'(res_q[3]) - 32'(res_q[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_INT;
      li_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      for (int k = 0; k < 4; k++) begin
        prev_q[k]  <= '0;
        integ_q[k] <= '0;
      end
    end else begin
      if ((state_q == S_MIX_B) && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            li_q    <= '0;
            state_q <= S_ERR;
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!div_busy) begin
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          ph_q    <= PH_INT;
          state_q <= S_MUL_GO;
        end
        S_MUL_GO: state_q <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (!mac_busy) begin
            case (ph_q)
              PH_INT: state_q <= S_INT;
              PH_DER: begin
                ph_q    <= PH_P;
                state_q <= S_MUL_GO;
              end
              PH_P: begin
                ph_q    <= PH_I;
                state_q <= S_MUL_GO;
              end
              PH_I: begin
                ph_q    <= PH_D;
                state_q <= S_MUL_GO;
              end
              default: state_q <= S_LOOP_END;
            endcase
          end
        end
        S_INT: begin
          if (e_mag > {2'b00, dead_band_q}) begin
            integ_q[li_q] <= integ_d;
          end
          ph_q    <= PH_DER;
          state_q <= S_MUL_GO;
        end
        S_LOOP_END: begin
          prev_q[li_q] <= e_q;
          if (li_q == 2'd3) begin
            state_q <= S_MIX_A;
          end else begin
            li_q    <= li_q + 2'd1;
            state_q <= (li_q == 2'd0) ? S_ERR : S_DIV_GO;
          end
        end
        S_MIX_A: state_q <= S_MIX_B;
        S_MIX_B: begin
          if (!out_valid_q || m_axis_tready_i) begin
            if (idle_q) begin
              out_data_q <= {IDLE_PULSE, IDLE_PULSE, IDLE_PULSE, IDLE_PULSE};
              for (int k = 0; k < 4; k++) begin
                integ_q[k] <= '0;
              end
            end else begin
              out_data_q <= {sat_pulse(base - ma - mb), sat_pulse(base + ma - mb),
                             sat_pulse(base - ma + mb), sat_pulse(base + ma + mb)};
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_idle_mac_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mac_busy && !div_busy)
    else $error("serial unit busy while idle");

  a_out_from_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_MIX_B))
    else $error("result raised outside mix step");

  a_loop_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOP_END) |-> !mac_busy && (ph_q == PH_D))
    else $error("loop closed before last product");

endmodule
